// File: design/omsc_pkg.sv
// ---------------------------------------------------------------------------
// omsc_pkg - shared types and constants for the ordered multiset
// Key and count widths, operation and status codes, and the control
// bundle that the sequencer broadcasts to the cell row.
// ---------------------------------------------------------------------------
package omsc_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 30;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FUNC_W   = 2;
  localparam int STAT_W   = 2;
  localparam int GROUP_SZ = 32;
  localparam int N_GROUP  = (CAPACITY + GROUP_SZ - 1) / GROUP_SZ;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

  // per-cycle control broadcast to the row
  typedef struct packed {
    logic eval;       // cells latch their compare flag
    logic cmp_gt;     // compare is strict greater (insert) instead of >=
    logic ins_apply;  // shift right and insert the key
    logic del_apply;  // shift left over the first matching cell
    logic grp_en;     // capture the per-group hit reduction
    logic fin_en;     // capture the final hit reduction
  } cell_ctrl_t;

endpackage

// File: design/ordered_multiset_ceiling.sv
// ---------------------------------------------------------------------------
// ordered_multiset_ceiling - bounded sorted multiset with ceiling lookup
// Insert, delete-one-copy and ceiling query over up to 1024 keys.
// ---------------------------------------------------------------------------
// Keys sit in ascending order in a row of cells, one key per cell. For each
// item the cells compare the key, the first flagged cell is found through two
// registered reduction levels (32 groups of 32 cells), and in the last cycle
// the result is loaded into the output register while the whole row shifts
// one place for an insert or a delete; only then is the next item accepted.
// A result waiting in the output register does not hold off the next item
// until that item's own result is ready. Each item gives exactly one result
// carrying status and the key count after the operation; an insert into a
// full store or a delete of an absent key leaves the store untouched. Reset
// clears the state, key count, output valid and cell flags, not the keys.
module ordered_multiset_ceiling (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [29:0] key_value, [31:30] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [29:0] result_key, [40:30] stored_count, [47:41] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_GRP  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                    state_r;
  logic [2:0]                    state_nxt;
  logic [omsc_pkg::FUNC_W-1:0]   func_r;
  logic [omsc_pkg::KEY_W-1:0]    key_r;
  logic [omsc_pkg::CNT_W-1:0]    count_r;
  logic [omsc_pkg::CNT_W-1:0]    count_nxt;
  logic                          out_valid_r;
  logic [omsc_pkg::KEY_W-1:0]    out_key_r;
  logic [omsc_pkg::STAT_W-1:0]   out_stat_r;
  logic [omsc_pkg::CNT_W-1:0]    out_cnt_r;

  logic                          in_fire;
  logic                          out_free;
  logic                          done_go;
  logic                          found;
  logic [omsc_pkg::KEY_W-1:0]    ceil_key;
  logic [omsc_pkg::KEY_W-1:0]    res_key;
  logic [omsc_pkg::STAT_W-1:0]   res_stat;
  logic                          do_ins;
  logic                          do_del;
  omsc_pkg::cell_ctrl_t          ctrl;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign done_go   = (state_r == ST_DONE) & out_free;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EVAL;
      end
      ST_EVAL: state_nxt = ST_GRP;
      ST_GRP:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result and store update
  always_comb begin
    res_key   = '0;
    res_stat  = omsc_pkg::STAT_OK;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    count_nxt = count_r;
    unique case (func_r)
      omsc_pkg::FUNC_INSERT: begin
        if (count_r == omsc_pkg::CNT_W'(omsc_pkg::CAPACITY)) begin
          res_stat = omsc_pkg::STAT_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + omsc_pkg::CNT_W'(1);
        end
      end
      omsc_pkg::FUNC_DELETE: begin
        if (found && (ceil_key == key_r)) begin
          do_del    = 1'b1;
          count_nxt = count_r - omsc_pkg::CNT_W'(1);
        end else begin
          res_stat = omsc_pkg::STAT_MISS;
        end
      end
      omsc_pkg::FUNC_QUERY: begin
        if (found) begin
          res_key = ceil_key;
        end else begin
          res_stat = omsc_pkg::STAT_MISS;
        end
      end
      default: begin
        res_stat = omsc_pkg::STAT_OK;
      end
    endcase
  end

  // control broadcast to the row
  always_comb begin
    ctrl.eval      = (state_r == ST_EVAL);
    ctrl.cmp_gt    = (func_r == omsc_pkg::FUNC_INSERT);
    ctrl.ins_apply = done_go & do_ins;
    ctrl.del_apply = done_go & do_del;
    ctrl.grp_en    = (state_r == ST_GRP);
    ctrl.fin_en    = (state_r == ST_FIN);
  end

  omsc_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .key_in     (key_r),
    .count      (count_r),
    .found_o    (found),
    .ceil_key_o (ceil_key)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input item and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_tuser;
      key_r  <= in_tdata[omsc_pkg::KEY_W-1:0];
    end
    if (done_go) begin
      out_key_r  <= res_key;
      out_stat_r <= res_stat;
      out_cnt_r  <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_key_r};
  assign out_tuser  = out_stat_r;

  // the key count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= omsc_pkg::CNT_W'(omsc_pkg::CAPACITY))
    else $error("key count above capacity");

  // a successful delete lowers the count by one
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.del_apply |=> count_r == $past(count_r) - omsc_pkg::CNT_W'(1))
    else $error("delete did not lower the count");

  // an accepted item starts the compare in the next cycle
  a_start_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_EVAL)
    else $error("accepted item did not start");

  // the store never shifts both ways at once
  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.ins_apply && ctrl.del_apply))
    else $error("insert and delete shift together");

endmodule

// File: design/omsc_cell.sv
// ---------------------------------------------------------------------------
// omsc_cell - one slot of the sorted key row
// Holds one key and a compare flag, and takes a key from its left or right
// neighbor when the row shifts.
// ---------------------------------------------------------------------------
module omsc_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  omsc_pkg::cell_ctrl_t         ctrl,
  input  logic [omsc_pkg::KEY_W-1:0]   key_in,
  input  logic                         occupied,
  input  logic                         at_end,
  input  logic [omsc_pkg::KEY_W-1:0]   left_key,
  input  logic                         left_flag,
  input  logic [omsc_pkg::KEY_W-1:0]   right_key,
  output logic [omsc_pkg::KEY_W-1:0]   key_o,
  output logic                         flag_o,
  output logic                         hit_o
);

  logic [omsc_pkg::KEY_W-1:0] key_r;
  logic [omsc_pkg::KEY_W-1:0] key_nxt;
  logic                       flag_r;
  logic                       flag_nxt;

  // compare, then shift
  always_comb begin
    key_nxt  = key_r;
    flag_nxt = flag_r;
    if (ctrl.eval) begin
      flag_nxt = occupied && (ctrl.cmp_gt ? (key_r > key_in) : (key_r >= key_in));
    end
    if (ctrl.ins_apply && (flag_r || at_end)) begin
      key_nxt = left_flag ? left_key : key_in;
    end
    if (ctrl.del_apply && flag_r) begin
      key_nxt = right_key;
    end
  end

  // key storage carries no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
  end

  // first cell of the row whose flag is set
  assign hit_o  = flag_r & ~left_flag;
  assign key_o  = key_r;
  assign flag_o = flag_r;

endmodule

// File: design/omsc_chain.sv
// ---------------------------------------------------------------------------
// omsc_chain - row of key cells with a two-level hit reduction
// Cells hold the keys in ascending order; the first flagged cell is picked
// out through registered per-group and final reductions.
// ---------------------------------------------------------------------------
module omsc_chain (
  input  logic                         clk,
  input  logic                         rst_n,
  input  omsc_pkg::cell_ctrl_t         ctrl,
  input  logic [omsc_pkg::KEY_W-1:0]   key_in,
  input  logic [omsc_pkg::CNT_W-1:0]   count,
  output logic                         found_o,
  output logic [omsc_pkg::KEY_W-1:0]   ceil_key_o
);

  logic [omsc_pkg::KEY_W-1:0] key_w  [omsc_pkg::CAPACITY];
  logic                       flag_w [omsc_pkg::CAPACITY];
  logic                       hit_w  [omsc_pkg::CAPACITY];

  logic [omsc_pkg::KEY_W-1:0] grp_key_r   [omsc_pkg::N_GROUP];
  logic [omsc_pkg::KEY_W-1:0] grp_key_nxt [omsc_pkg::N_GROUP];
  logic                       grp_hit_r   [omsc_pkg::N_GROUP];
  logic                       grp_hit_nxt [omsc_pkg::N_GROUP];

  logic                       found_r;
  logic                       found_nxt;
  logic [omsc_pkg::KEY_W-1:0] ceil_key_r;
  logic [omsc_pkg::KEY_W-1:0] ceil_key_nxt;

  // cell row
  for (genvar i = 0; i < omsc_pkg::CAPACITY; i++) begin : g_cell
    logic [omsc_pkg::KEY_W-1:0] left_key;
    logic                       left_flag;
    logic [omsc_pkg::KEY_W-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key  = '0;
      assign left_flag = 1'b0;
    end else begin : g_mid
      assign left_key  = key_w[i-1];
      assign left_flag = flag_w[i-1];
    end

    if (i == omsc_pkg::CAPACITY - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_inner
      assign right_key = key_w[i+1];
    end

    omsc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .key_in    (key_in),
      .occupied  (omsc_pkg::CNT_W'(i) < count),
      .at_end    (omsc_pkg::CNT_W'(i) == count),
      .left_key  (left_key),
      .left_flag (left_flag),
      .right_key (right_key),
      .key_o     (key_w[i]),
      .flag_o    (flag_w[i]),
      .hit_o     (hit_w[i])
    );
  end

  // per-group reduction, at most one hit in the whole row
  always_comb begin
    for (int g = 0; g < omsc_pkg::N_GROUP; g++) begin
      grp_key_nxt[g] = '0;
      grp_hit_nxt[g] = 1'b0;
      for (int j = 0; j < omsc_pkg::GROUP_SZ; j++) begin
        if (g * omsc_pkg::GROUP_SZ + j < omsc_pkg::CAPACITY) begin
          if (hit_w[g * omsc_pkg::GROUP_SZ + j]) begin
            grp_key_nxt[g] = grp_key_nxt[g] | key_w[g * omsc_pkg::GROUP_SZ + j];
            grp_hit_nxt[g] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.grp_en) begin
      for (int g = 0; g < omsc_pkg::N_GROUP; g++) begin
        grp_key_r[g] <= grp_key_nxt[g];
        grp_hit_r[g] <= grp_hit_nxt[g];
      end
    end
  end

  // final reduction over the groups
  always_comb begin
    found_nxt    = 1'b0;
    ceil_key_nxt = '0;
    for (int g = 0; g < omsc_pkg::N_GROUP; g++) begin
      if (grp_hit_r[g]) begin
        found_nxt    = 1'b1;
        ceil_key_nxt = ceil_key_nxt | grp_key_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin_en) begin
      found_r    <= found_nxt;
      ceil_key_r <= ceil_key_nxt;
    end
  end

  assign found_o    = found_r;
  assign ceil_key_o = ceil_key_r;

endmodule
